>>> hdl/hfrs_pkg.sv
// ----------------------------------------------------------------------------
// hfrs_pkg
// Shared types and constants for the heap free run search block.
// ----------------------------------------------------------------------------
package hfrs_pkg;

  localparam int MAP_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int SIZE_W    = 11;
  localparam int POS_W     = ($clog2(MAP_DEPTH + 1) > SIZE_W) ? $clog2(MAP_DEPTH + 1) : SIZE_W;
  localparam int SUM_W     = ((POS_W > SIZE_W) ? POS_W : SIZE_W) + 1;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int START_W   = 10;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_NEXT  = 2'd1,
    FIT_BEST  = 2'd2,
    FIT_WORST = 2'd3
  } fit_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRATEGY     = 2'd0,
    CFG_REGION_START = 2'd1,
    CFG_REGION_SIZE  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic write;
    logic scan;
    logic finish;
  } hfrs_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_done;
  } hfrs_status_t;

endpackage

>>> hdl/hfrs_ctrl.sv
// ----------------------------------------------------------------------------
// hfrs_ctrl
// Sequencer: map clearing after reset, request decode, scan, result strobe.
// ----------------------------------------------------------------------------
module hfrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                mode,
  input  hfrs_pkg::hfrs_status_t status,
  output hfrs_pkg::hfrs_cmd_t    cmd,
  output logic                busy,
  output logic                done
);
  import hfrs_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FINISH = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (mode) begin
            cmd.load   = 1'b1;
            state_next = S_SCAN;
          end else begin
            cmd.write  = 1'b1;
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

>>> hdl/hfrs_datapath.sv
// ----------------------------------------------------------------------------
// hfrs_datapath
// Used/free map memory, configuration registers, run tracking and selection.
// ----------------------------------------------------------------------------
module hfrs_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  hfrs_pkg::hfrs_cmd_t          cmd,
  output hfrs_pkg::hfrs_status_t       status,
  input  logic                         cfg_we,
  input  logic [hfrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfrs_pkg::CFG_W-1:0]   cfg_data,
  input  logic [9:0]                   map_address,
  input  logic                         mark_used,
  input  logic [hfrs_pkg::SIZE_W-1:0]  request_size,
  output logic                         found,
  output logic [hfrs_pkg::START_W-1:0] run_start
);
  import hfrs_pkg::*;

  // configuration
  fit_t              strategy;
  logic [9:0]        region_start;
  logic [SIZE_W-1:0] region_size;

  // map memory
  logic              mem [MAP_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_wdata;
  logic              rd_bit;

  logic [ADDR_W-1:0] clr_addr;
  logic [POS_W-1:0]  nfp;
  logic [POS_W-1:0]  end_pos;
  logic [SIZE_W-1:0] need;
  logic [POS_W-1:0]  scan_addr;
  logic              rd_valid;
  logic [POS_W-1:0]  rd_pos;

  logic              in_run;
  logic [POS_W-1:0]  cur_start;
  logic [POS_W-1:0]  cur_len;
  logic              hit;
  logic [POS_W-1:0]  best_start;
  logic [POS_W-1:0]  best_len;
  logic [POS_W-1:0]  best_after;

  logic [SUM_W-1:0]  end_sum;
  logic [POS_W-1:0]  end_calc;
  logic [POS_W-1:0]  from_calc;
  logic              issue;
  logic              close;
  logic              fits;
  logic              take;
  logic [POS_W-1:0]  close_after;
  logic              final_hit;
  logic [POS_W-1:0]  final_start;
  logic [POS_W-1:0]  final_after;
  logic              addr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      strategy     <= FIT_FIRST;
      region_start <= '0;
      region_size  <= SIZE_W'(1024);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STRATEGY:     strategy     <= fit_t'(cfg_data[1:0]);
        CFG_REGION_START: region_start <= cfg_data[9:0];
        CFG_REGION_SIZE:  region_size  <= cfg_data[SIZE_W-1:0];
        default:          ;
      endcase
    end
  end

  // region bounds and scan origin
  always_comb begin
    end_sum = SUM_W'(region_start) + SUM_W'(region_size);
    if (end_sum > SUM_W'(MAP_DEPTH)) begin
      end_calc = POS_W'(MAP_DEPTH);
    end else begin
      end_calc = end_sum[POS_W-1:0];
    end
    from_calc = POS_W'(region_start);
    if (strategy == FIT_NEXT && SUM_W'(nfp) >= SUM_W'(region_start) &&
        nfp < end_calc) begin
      from_calc = nfp;
    end
  end

  assign addr_ok = (SUM_W'(map_address) < SUM_W'(MAP_DEPTH));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 1'b0;
    if (cmd.clear) begin
      mem_we = 1'b1;
    end else if (cmd.write && addr_ok) begin
      mem_we    = 1'b1;
      mem_waddr = ADDR_W'(map_address);
      mem_wdata = mark_used;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_bit <= mem[scan_addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign issue             = cmd.scan && (scan_addr < end_pos);
  assign status.clear_last = (clr_addr == ADDR_W'(MAP_DEPTH - 1));
  assign status.scan_done  = !issue && !rd_valid;

  // run closing and strategy selection
  always_comb begin
    close       = (cmd.scan && rd_valid && rd_bit) || cmd.finish;
    close_after = cmd.finish ? end_pos : rd_pos;
    fits        = in_run && (SUM_W'(cur_len) >= SUM_W'(need));
    case (strategy)
      FIT_BEST:  take = fits && (!hit || cur_len < best_len);
      FIT_WORST: take = fits && (!hit || cur_len > best_len);
      default:   take = fits && !hit;
    endcase
    take        = take && close;
    final_hit   = hit || take;
    final_start = take ? cur_start : best_start;
    final_after = take ? close_after : best_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      in_run   <= 1'b0;
      hit      <= 1'b0;
      nfp      <= '0;
    end else if (cmd.load) begin
      end_pos   <= end_calc;
      scan_addr <= from_calc;
      need      <= request_size;
      rd_valid  <= 1'b0;
      in_run    <= 1'b0;
      hit       <= 1'b0;
      found     <= 1'b0;
      run_start <= '0;
    end else if (cmd.write) begin
      found     <= 1'b0;
      run_start <= '0;
    end else if (cmd.scan) begin
      rd_valid <= issue;
      rd_pos   <= scan_addr;
      if (issue) scan_addr <= scan_addr + 1'b1;
      if (rd_valid) begin
        if (!rd_bit) begin
          if (!in_run) begin
            in_run    <= 1'b1;
            cur_start <= rd_pos;
            cur_len   <= POS_W'(1);
          end else begin
            cur_len <= cur_len + 1'b1;
          end
        end else begin
          in_run <= 1'b0;
        end
      end
      if (take) begin
        hit        <= 1'b1;
        best_start <= cur_start;
        best_len   <= cur_len;
        best_after <= close_after;
      end
    end else if (cmd.finish) begin
      found     <= final_hit;
      run_start <= final_hit ? START_W'(final_start) : '0;
      if (final_hit && strategy == FIT_NEXT) nfp <= final_after;
    end
  end

endmodule

>>> hdl/heap_free_run_search_top.sv
// ----------------------------------------------------------------------------
// heap_free_run_search_top
// Free run allocator search over a one-bit used/free heap map.
// ----------------------------------------------------------------------------
// map write: done strobes in the cycle after the accepting edge, then the block returns to idle
// search: the block loads, scans from the origin to the region end, finishes and strobes done
// the scan does one map read per cycle, which sets the search time
// reset: busy while the map is cleared one entry per cycle
// results are strobed on done for one cycle and cannot be stalled
module heap_free_run_search_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic                           cfg_we,
  input  logic [hfrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfrs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           mode,
  input  logic [9:0]                     map_address,
  input  logic                           mark_used,
  input  logic [hfrs_pkg::SIZE_W-1:0]    request_size,
  output logic                           found,
  output logic [hfrs_pkg::START_W-1:0]   run_start
);
  import hfrs_pkg::*;

  hfrs_cmd_t    cmd;
  hfrs_status_t status;

  hfrs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  hfrs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .map_address  (map_address),
    .mark_used    (mark_used),
    .request_size (request_size),
    .found        (found),
    .run_start    (run_start)
  );

endmodule

>>> hdl/hfrs_checker.sv
// ----------------------------------------------------------------------------
// hfrs_checker
// Port level checks for the heap free run search block, bound to the top.
// ----------------------------------------------------------------------------
module hfrs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic                           found,
  input logic [hfrs_pkg::START_W-1:0]   run_start
);

  // map clearing keeps the block busy right after reset
  a_busy_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // an accepted request is worked on
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block idle");

  // a result is strobed for one cycle only
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // no request is taken in the result cycle
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("idle while strobing a result");

  // a miss or a map write reports address zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (run_start == '0))
    else $error("nonzero run start without a hit");

endmodule

bind heap_free_run_search_top hfrs_checker u_hfrs_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .found     (found),
  .run_start (run_start)
);

>>> tb/tb_heap_free_run_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heap_free_run_search_top
// Self-checking bench for the heap free run search block. Map writes and
// searches are sent through the start/busy handshake. A local copy of the
// used map, next fit position and region registers predicts found/run_start
// for every accepted request, and each done strobe is checked in order.
// Directed tests cover the region edges, zero and full-size requests, ties
// and next fit restarts. Random phases then vary strategy and region.
// ----------------------------------------------------------------------------
module tb_heap_free_run_search_top;
  import hfrs_pkg::*;

  typedef struct {
    logic             found;
    logic [START_W-1:0] run_start;
  } run_result_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 done;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 mode;
  logic [9:0]           map_address;
  logic                 mark_used;
  logic [SIZE_W-1:0]    request_size;
  logic                 found;
  logic [START_W-1:0]   run_start;

  // local copy of the block state
  bit                   heap_used [MAP_DEPTH];
  logic [POS_W-1:0]     next_fit_pos;
  fit_t                 fit_mode;
  int                   heap_base;
  int                   heap_span;

  run_result_t          pending_runs [$];
  int                   mismatch_count;

  heap_free_run_search_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .map_address  (map_address),
    .mark_used    (mark_used),
    .request_size (request_size),
    .found        (found),
    .run_start    (run_start)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** heap_free_run_search_top: FAILED **");
    $finish;
  end

  // scan the region for maximal free runs and pick one per the strategy
  function automatic void find_free_run(input logic [SIZE_W-1:0] need,
                                        output logic hit,
                                        output logic [START_W-1:0] run_at);
    int lim;
    int origin;
    int a;
    int s;
    int len;
    int best_len;
    int after;
    logic take;
    lim = heap_base + heap_span;
    if (lim > MAP_DEPTH) lim = MAP_DEPTH;
    origin = heap_base;
    if (fit_mode == FIT_NEXT && int'(next_fit_pos) >= heap_base && int'(next_fit_pos) < lim)
      origin = next_fit_pos;
    hit = 1'b0;
    run_at = '0;
    best_len = 0;
    after = 0;
    a = origin;
    while (a < lim) begin
      s = a;
      while (a < lim && !heap_used[a]) a++;
      len = a - s;
      if (len > 0 && len >= int'(need)) begin
        case (fit_mode)
          FIT_BEST:  take = !hit || len < best_len;
          FIT_WORST: take = !hit || len > best_len;
          default:   take = 1'b1;
        endcase
        if (take) begin
          hit = 1'b1;
          best_len = len;
          run_at = s[START_W-1:0];
          after = a;
          if (fit_mode == FIT_FIRST || fit_mode == FIT_NEXT) break;
        end
      end
      a++;
    end
    if (hit && fit_mode == FIT_NEXT) next_fit_pos = after[POS_W-1:0];
  endfunction

  // one request through the handshake; start stays high until the caller lowers it
  task automatic send_request(input logic m, input logic [9:0] addr, input logic mark,
                              input logic [SIZE_W-1:0] size);
    run_result_t res;
    start        <= 1'b1;
    mode         <= m;
    map_address  <= addr;
    mark_used    <= mark;
    request_size <= size;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (m == 1'b0) begin
      heap_used[addr] = mark;
      res.found = 1'b0;
      res.run_start = '0;
    end else begin
      find_free_run(size, res.found, res.run_start);
    end
    pending_runs.push_back(res);
  endtask

  task automatic write_entry(input int addr, input bit mark);
    send_request(1'b0, addr[9:0], mark, SIZE_W'($urandom_range(0, 1024)));
  endtask

  task automatic search_run(input int size);
    send_request(1'b1, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                 size[SIZE_W-1:0]);
  endtask

  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_runs.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // only while idle
  task automatic cfg_write(input cfg_idx_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_STRATEGY:     fit_mode  = fit_t'(value[1:0]);
      CFG_REGION_START: heap_base = value & 32'h3FF;
      CFG_REGION_SIZE:  heap_span = value & 32'h7FF;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_region(input fit_t strat, input int base, input int span);
    wait_drain();
    cfg_write(CFG_STRATEGY, strat);
    cfg_write(CFG_REGION_START, base);
    cfg_write(CFG_REGION_SIZE, span);
  endtask

  // reset defaults: full region, first fit
  task automatic test_map_writes();
    write_entry(0, 1'b1);
    write_entry(1023, 1'b1);
    write_entry(512, 1'b0);
    search_run(1024);
    search_run(1022);
    search_run(0);
  endtask

  task automatic test_region_edges();
    set_region(FIT_FIRST, 0, 0);
    search_run(0);
    set_region(FIT_FIRST, 1000, 1024);
    search_run(23);
    search_run(24);
    set_region(FIT_FIRST, 1023, 1024);
    search_run(0);
    set_region(FIT_FIRST, 0, 1);
    search_run(0);
  endtask

  // runs 1-3, 5-7, 9-12, 14-19 in [0,20)
  task automatic test_fit_strategies();
    set_region(FIT_FIRST, 0, 20);
    write_entry(4, 1'b1);
    write_entry(8, 1'b1);
    write_entry(13, 1'b1);
    search_run(3);
    set_region(FIT_BEST, 0, 20);
    search_run(4);
    search_run(3);
    set_region(FIT_WORST, 0, 20);
    search_run(0);
    search_run(7);
  endtask

  task automatic test_next_fit();
    set_region(FIT_NEXT, 0, 20);
    search_run(3);
    search_run(3);
    search_run(5);
    search_run(3);
    write_entry(4, 1'b0);
    search_run(4);
    search_run(10);
  endtask

  task automatic test_random_phases();
    int issued;
    int phase_items;
    int burst_left;
    int pick;
    int base;
    int span;
    int lim;
    int size;
    issued = 0;
    burst_left = $urandom_range(1, 12);
    while (issued < 580) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        base = $urandom_range(0, 1023);
        span = $urandom_range(1, 64);
      end else if (pick < 80) begin
        base = 0;
        span = 1024;
      end else if (pick < 85) begin
        base = 1023;
        span = $urandom_range(0, 1024);
      end else if (pick < 88) begin
        base = $urandom_range(0, 1023);
        span = 0;
      end else begin
        base = $urandom_range(0, 1023);
        span = $urandom_range(0, 1024);
      end
      set_region(fit_t'($urandom_range(0, 3)), base, span);
      lim = (base + span > MAP_DEPTH) ? MAP_DEPTH : base + span;
      phase_items = $urandom_range(20, 60);
      repeat (phase_items) begin
        if ($urandom_range(0, 99) < 55) begin
          if (lim > base && $urandom_range(0, 99) < 85)
            write_entry($urandom_range(base, lim - 1), $urandom_range(0, 99) < 45);
          else
            write_entry($urandom_range(0, 1023), 1'($urandom_range(0, 1)));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 60)      size = $urandom_range(0, 8);
          else if (pick < 80) size = $urandom_range(0, span);
          else if (pick < 92) size = $urandom_range(0, 1024);
          else if (pick < 96) size = 0;
          else                size = 1024;
          search_run(size);
        end
        issued++;
        if ($urandom_range(0, 99) == 0) begin
          wait_drain();
        end else if (burst_left == 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 70)      sender_gap($urandom_range(1, 5));
          else if (pick < 95) sender_gap($urandom_range(6, 40));
          else                sender_gap($urandom_range(100, 300));
          burst_left = $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
  endtask

  // compare each strobed result with the oldest prediction
  always @(posedge clk) begin : check_results
    run_result_t want;
    if (!rst && done) begin
      if (pending_runs.size() == 0) begin
        $display("%0t: unexpected result found %0b run_start %0d", $time, found, run_start);
        mismatch_count++;
      end else begin
        want = pending_runs.pop_front();
        if (found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, found);
          mismatch_count++;
        end
        if (run_start !== want.run_start) begin
          $display("%0t: run_start expected %0d actual %0d", $time, want.run_start,
                   run_start);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_STRATEGY;
    cfg_data     = '0;
    mode         = 1'b0;
    map_address  = '0;
    mark_used    = 1'b0;
    request_size = '0;
    mismatch_count = 0;
    next_fit_pos = '0;
    fit_mode     = FIT_FIRST;
    heap_base    = 0;
    heap_span    = 1024;
    foreach (heap_used[i]) heap_used[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_map_writes();
    test_region_edges();
    test_fit_strategies();
    test_next_fit();
    test_random_phases();

    wait_drain();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && pending_runs.size() == 0) begin
      $display("** heap_free_run_search_top: PASSED **");
    end else begin
      $display("** heap_free_run_search_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/hfrs_pkg.sv
hdl/hfrs_ctrl.sv
hdl/hfrs_datapath.sv
hdl/heap_free_run_search_top.sv
hdl/hfrs_checker.sv
tb/tb_heap_free_run_search_top.sv
